/* rtl/oops_pkg.sv */
// Package for the on/off packet scheduler: field widths, time constants,
// register and opcode codes. No dependencies.
`timescale 1ns / 1ps

package oops_pkg;

  localparam int unsigned SecW      = 32;
  localparam int unsigned UsW       = 20;
  localparam int unsigned SizeW     = 16;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned RemW      = 10;  // ns below one microsecond
  localparam int unsigned PerUsW    = 23;  // period in whole us, up to 4294967
  localparam int unsigned SpanSecW  = 13;  // span in whole seconds, up to 4294

  localparam int unsigned UsPerSec  = 1000000;
  localparam int unsigned NsPerUs   = 1000;
  localparam int unsigned UsMax     = UsPerSec - 1;
  localparam int unsigned SizeReset = 1522;

  // Reciprocals: x / 1000 = (x * MagicMs) >> ShiftMs, x / 10^6 = (x * MagicUs) >> ShiftUs,
  // exact for every 32-bit x.
  localparam int unsigned MagicW    = 31;
  localparam logic [MagicW-1:0] MagicMs = 31'd274877907;
  localparam int unsigned ShiftMs   = 38;
  localparam logic [MagicW-1:0] MagicUs = 31'd1125899907;
  localparam int unsigned ShiftUs   = 50;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PERIOD_FIRST  = 3'd0,
    REG_PERIOD_SECOND = 3'd1,
    REG_SIZE_FIRST    = 3'd2,
    REG_SIZE_SECOND   = 3'd3,
    REG_SPAN_FIRST    = 3'd4,
    REG_SPAN_SECOND   = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

endpackage

/* rtl/oops_if.sv */
// Channel interfaces of the on/off packet scheduler: item, result and
// configuration write. Depends on oops_pkg.
`timescale 1ns / 1ps

interface oops_item_if import oops_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            opcode;
  logic [SecW-1:0] base_sec;
  logic [UsW-1:0]  base_us;

  modport source (output valid, output opcode, output base_sec, output base_us, input ready);
  modport sink   (input valid, input opcode, input base_sec, input base_us, output ready);
endinterface

interface oops_result_if import oops_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SecW-1:0]  send_sec;
  logic [UsW-1:0]   send_us;
  logic [SizeW-1:0] packet_size;
  logic             phase;

  modport source (output valid, output send_sec, output send_us, output packet_size,
                  output phase, input ready);
  modport sink   (input valid, input send_sec, input send_us, input packet_size,
                  input phase, output ready);
endinterface

interface oops_cfg_if import oops_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/on_off_packet_scheduler.sv */
// Channel  | Dir | Handshake          | Payload
// in_i     | in  | valid/ready        | opcode, base_sec, base_us
// out_o    | out | valid/ready        | send_sec, send_us, packet_size, phase
// cfg_i    | in  | valid/ready        | index, data (register write)
//
// One item per cycle unless stalled; its result shows in the cycle after it is taken.
// The schedule state is updated in the same cycle, so the next item follows at once.
// A write to a period or span register splits it into whole us / seconds plus remainder
// in the reciprocal-multiply pipeline d1..d3; both ready lines stay low meanwhile.
// Items are taken with no write offered and the result register empty or being drained.
// Reset clears the schedule, the derived periods and spans, and sets sizes to 1522.
// Depends on oops_pkg and oops_if.
`timescale 1ns / 1ps

module on_off_packet_scheduler import oops_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  oops_item_if.sink     in_i,
  oops_result_if.source out_o,
  oops_cfg_if.sink      cfg_i
);

  // Configuration, kept in split form
  logic [PerUsW-1:0]   p1_us_q, p2_us_q;
  logic [RemW-1:0]     p1_rem_q, p2_rem_q;
  logic [SpanSecW-1:0] s1_sec_q, s2_sec_q;
  logic [UsW-1:0]      s1_us_q, s2_us_q;
  logic [SizeW-1:0]    size1_q, size2_q;

  // Derivation pipeline
  logic                  d1_vld_q, d2_vld_q, d3_vld_q;
  cfg_reg_e              d1_idx_q, d2_idx_q, d3_idx_q;
  logic [CfgDataW-1:0]   d1_val_q, d2_val_q, d3_val_q;
  logic [CfgDataW+MagicW-1:0] d2_prod_q;
  logic [PerUsW-1:0]     d3_quo_q;
  logic [CfgDataW-1:0]   d3_qc_q;
  logic                  d1_span, d2_span;
  logic [MagicW-1:0]     d1_magic;
  logic [PerUsW-1:0]     d2_quo;
  logic [UsW-1:0]        d2_div;
  logic [PerUsW+UsW-1:0] d2_qc;
  logic [CfgDataW-1:0]   d3_rem;
  logic                  busy;
  logic                  cfg_acc, cfg_derive;

  // Schedule state
  logic [SecW-1:0] next_sec_q, next_sec_d;
  logic [UsW-1:0]  next_us_q, next_us_d;
  logic [RemW-1:0] next_rem_q, next_rem_d;
  logic [SecW-1:0] ps_sec_q, ps_sec_d;
  logic [UsW-1:0]  ps_us_q, ps_us_d;
  logic [SecW-1:0] dsec_q, dsec_d;  // next_sec - ps_sec, wrapped
  logic            in_second_q, in_second_d;

  // Result register
  logic             out_vld_q;
  logic [SecW-1:0]  out_sec_q;
  logic [UsW-1:0]   out_us_q;
  logic [SizeW-1:0] out_size_q;
  logic             out_phase_q;

  // Step datapath
  logic                in_acc, is_start, adv_second;
  logic [PerUsW-1:0]   per_us;
  logic [RemW-1:0]     per_rem;
  logic                per_zero;
  logic [SpanSecW-1:0] spn_sec;
  logic [UsW-1:0]      spn_us;
  logic                spn_zero;
  logic [UsW-1:0]      base_us_sat;
  logic [RemW:0]       rem_sum;
  logic                rem_c;
  logic [RemW-1:0]     rem_new;
  logic [PerUsW-1:0]   us_sum;
  logic [2:0]          sec_c;
  logic [UsW-1:0]      us_new;
  logic [SecW-1:0]     sec_new, dsec_new, el_sec;
  logic                us_lt;
  logic [UsW-1:0]      el_us;
  logic                past;
  logic [SecW-1:0]     j_base_sec, j_sec;
  logic [UsW-1:0]      j_base_us, j_us;
  logic [UsW:0]        j_sum;
  logic                j_c;
  logic                do_jump;

  // ---------------- handshakes ----------------
  assign busy        = d1_vld_q || d2_vld_q || d3_vld_q;
  assign cfg_i.ready = !busy;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign in_i.ready  = !busy && !cfg_i.valid && (!out_vld_q || out_o.ready);
  assign in_acc      = in_i.valid && in_i.ready;

  assign cfg_derive = cfg_acc && (cfg_i.index == REG_PERIOD_FIRST ||
                                  cfg_i.index == REG_PERIOD_SECOND ||
                                  cfg_i.index == REG_SPAN_FIRST ||
                                  cfg_i.index == REG_SPAN_SECOND);

  // ---------------- configuration split ----------------
  always_comb begin
    d1_span  = d1_idx_q == REG_SPAN_FIRST || d1_idx_q == REG_SPAN_SECOND;
    d2_span  = d2_idx_q == REG_SPAN_FIRST || d2_idx_q == REG_SPAN_SECOND;
    d1_magic = d1_span ? MagicUs : MagicMs;
    d2_quo   = d2_span ? PerUsW'(d2_prod_q[ShiftUs+SpanSecW-1:ShiftUs])
                       : d2_prod_q[ShiftMs+PerUsW-1:ShiftMs];
    d2_div   = d2_span ? UsW'(UsPerSec) : UsW'(NsPerUs);
    d2_qc    = (PerUsW+UsW)'(d2_quo) * (PerUsW+UsW)'(d2_div);
    d3_rem   = d3_val_q - d3_qc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_vld_q <= 1'b0;
      d2_vld_q <= 1'b0;
      d3_vld_q <= 1'b0;
    end else begin
      d1_vld_q <= cfg_derive;
      d2_vld_q <= d1_vld_q;
      d3_vld_q <= d2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cfg_derive) begin
      d1_idx_q <= cfg_reg_e'(cfg_i.index);
      d1_val_q <= cfg_i.data;
    end
    d2_idx_q  <= d1_idx_q;
    d2_val_q  <= d1_val_q;
    d2_prod_q <= (CfgDataW+MagicW)'(d1_val_q) * (CfgDataW+MagicW)'(d1_magic);
    d3_idx_q  <= d2_idx_q;
    d3_val_q  <= d2_val_q;
    d3_quo_q  <= d2_quo;
    d3_qc_q   <= d2_qc[CfgDataW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_us_q  <= '0;
      p1_rem_q <= '0;
      p2_us_q  <= '0;
      p2_rem_q <= '0;
      s1_sec_q <= '0;
      s1_us_q  <= '0;
      s2_sec_q <= '0;
      s2_us_q  <= '0;
      size1_q  <= SizeW'(SizeReset);
      size2_q  <= SizeW'(SizeReset);
    end else begin
      if (cfg_acc) begin
        unique case (cfg_i.index)
          REG_SIZE_FIRST:  size1_q <= cfg_i.data[SizeW-1:0];
          REG_SIZE_SECOND: size2_q <= cfg_i.data[SizeW-1:0];
          default: ;
        endcase
      end
      if (d3_vld_q) begin
        unique case (d3_idx_q)
          REG_PERIOD_FIRST: begin
            p1_us_q  <= d3_quo_q;
            p1_rem_q <= d3_rem[RemW-1:0];
          end
          REG_PERIOD_SECOND: begin
            p2_us_q  <= d3_quo_q;
            p2_rem_q <= d3_rem[RemW-1:0];
          end
          REG_SPAN_FIRST: begin
            s1_sec_q <= d3_quo_q[SpanSecW-1:0];
            s1_us_q  <= d3_rem[UsW-1:0];
          end
          REG_SPAN_SECOND: begin
            s2_sec_q <= d3_quo_q[SpanSecW-1:0];
            s2_us_q  <= d3_rem[UsW-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  // ---------------- schedule step ----------------
  always_comb begin
    is_start   = in_i.opcode == OP_START;
    adv_second = !is_start && in_second_q;
    per_us     = adv_second ? p2_us_q  : p1_us_q;
    per_rem    = adv_second ? p2_rem_q : p1_rem_q;
    per_zero   = per_us == '0 && per_rem == '0;
    spn_sec    = adv_second ? s2_sec_q : s1_sec_q;
    spn_us     = adv_second ? s2_us_q  : s1_us_q;
    spn_zero   = spn_sec == '0 && spn_us == '0;
    base_us_sat = (in_i.base_us > UsW'(UsMax)) ? UsW'(UsMax) : in_i.base_us;

    // advance by one period: ns remainder, then microseconds, then seconds
    rem_sum = (RemW+1)'(next_rem_q) + (RemW+1)'(per_rem);
    rem_c   = rem_sum >= (RemW+1)'(NsPerUs);
    rem_new = rem_c ? RemW'(rem_sum - (RemW+1)'(NsPerUs)) : rem_sum[RemW-1:0];
    us_sum  = PerUsW'(next_us_q) + per_us + PerUsW'(rem_c);
    priority if (us_sum >= PerUsW'(5 * UsPerSec)) begin
      sec_c  = 3'd5;
      us_new = UsW'(us_sum - PerUsW'(5 * UsPerSec));
    end else if (us_sum >= PerUsW'(4 * UsPerSec)) begin
      sec_c  = 3'd4;
      us_new = UsW'(us_sum - PerUsW'(4 * UsPerSec));
    end else if (us_sum >= PerUsW'(3 * UsPerSec)) begin
      sec_c  = 3'd3;
      us_new = UsW'(us_sum - PerUsW'(3 * UsPerSec));
    end else if (us_sum >= PerUsW'(2 * UsPerSec)) begin
      sec_c  = 3'd2;
      us_new = UsW'(us_sum - PerUsW'(2 * UsPerSec));
    end else if (us_sum >= PerUsW'(UsPerSec)) begin
      sec_c  = 3'd1;
      us_new = UsW'(us_sum - PerUsW'(UsPerSec));
    end else begin
      sec_c  = 3'd0;
      us_new = us_sum[UsW-1:0];
    end
    sec_new  = next_sec_q + SecW'(sec_c);
    dsec_new = dsec_q + SecW'(sec_c);

    // elapsed time since phase start as (seconds, us), borrowing one second if needed;
    // a send time before the phase start counts as past the span
    us_lt  = us_new < ps_us_q;
    el_sec = dsec_new - SecW'(us_lt);
    el_us  = us_lt ? UsW'((UsW+1)'(us_new) + (UsW+1)'(UsPerSec) - (UsW+1)'(ps_us_q))
                   : us_new - ps_us_q;
    past   = (dsec_new == '0 && us_lt) || (el_sec > SecW'(spn_sec)) ||
             (el_sec == SecW'(spn_sec) && el_us > spn_us);

    // phase jump: move the phase start forward by the span
    j_base_sec = is_start ? in_i.base_sec : ps_sec_q;
    j_base_us  = is_start ? base_us_sat : ps_us_q;
    j_sum      = (UsW+1)'(j_base_us) + (UsW+1)'(spn_us);
    j_c        = j_sum >= (UsW+1)'(UsPerSec);
    j_us       = j_c ? UsW'(j_sum - (UsW+1)'(UsPerSec)) : j_sum[UsW-1:0];
    j_sec      = j_base_sec + SecW'(spn_sec) + SecW'(j_c);

    do_jump = per_zero || (!is_start && past && !(adv_second && spn_zero));

    if (do_jump) begin
      next_sec_d  = j_sec;
      next_us_d   = j_us;
      next_rem_d  = '0;
      ps_sec_d    = j_sec;
      ps_us_d     = j_us;
      dsec_d      = '0;
      in_second_d = !adv_second;
    end else if (is_start) begin
      next_sec_d  = in_i.base_sec;
      next_us_d   = base_us_sat;
      next_rem_d  = '0;
      ps_sec_d    = in_i.base_sec;
      ps_us_d     = base_us_sat;
      dsec_d      = '0;
      in_second_d = 1'b0;
    end else begin
      next_sec_d  = sec_new;
      next_us_d   = us_new;
      next_rem_d  = rem_new;
      ps_sec_d    = ps_sec_q;
      ps_us_d     = ps_us_q;
      dsec_d      = dsec_new;
      in_second_d = in_second_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_sec_q  <= '0;
      next_us_q   <= '0;
      next_rem_q  <= '0;
      ps_sec_q    <= '0;
      ps_us_q     <= '0;
      dsec_q      <= '0;
      in_second_q <= 1'b0;
    end else if (in_acc) begin
      next_sec_q  <= next_sec_d;
      next_us_q   <= next_us_d;
      next_rem_q  <= next_rem_d;
      ps_sec_q    <= ps_sec_d;
      ps_us_q     <= ps_us_d;
      dsec_q      <= dsec_d;
      in_second_q <= in_second_d;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (in_acc) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_sec_q   <= next_sec_d;
      out_us_q    <= next_us_d;
      out_size_q  <= in_second_d ? size2_q : size1_q;
      out_phase_q <= in_second_d;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.send_sec    = out_sec_q;
  assign out_o.send_us     = out_us_q;
  assign out_o.packet_size = out_size_q;
  assign out_o.phase       = out_phase_q;

endmodule

/* rtl/oops_checker.sv */
// Port-level checks for on_off_packet_scheduler, attached by bind.
// Depends on oops_pkg and the top level's channel interfaces.
`timescale 1ns / 1ps

module oops_checker import oops_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [SecW-1:0]  out_send_sec_i,
  input logic [UsW-1:0]   out_send_us_i,
  input logic [SizeW-1:0] out_size_i,
  input logic             out_phase_i,
  input logic             cfg_valid_i,
  input logic             cfg_ready_i
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_send_sec_i) &&
    $stable(out_send_us_i) && $stable(out_size_i) && $stable(out_phase_i))
    else $error("stalled result changed");

  // every accepted item shows its result in the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted item gave no result");

  // a result appears only after an accepted item
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result without an item");

  a_us_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_send_us_i < UsW'(UsPerSec))
    else $error("send_us out of range");

  // hold items off while a register write is pending
  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> !in_ready_i)
    else $error("item taken during configuration update");

endmodule

bind on_off_packet_scheduler oops_checker u_oops_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_send_sec_i (out_o.send_sec),
  .out_send_us_i  (out_o.send_us),
  .out_size_i     (out_o.packet_size),
  .out_phase_i    (out_o.phase),
  .cfg_valid_i    (cfg_i.valid),
  .cfg_ready_i    (cfg_i.ready)
);

/* test/tb_on_off_packet_scheduler.sv */
// Self-checking testbench for the on/off packet scheduler: directed and random
// schedules with random idling on both channels. Depends on oops_pkg and oops_if.
`timescale 1ns / 1ps

module tb_on_off_packet_scheduler;
  import oops_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned RandomItems = 600;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [SecW-1:0]  sec;
    logic [UsW-1:0]   us;
    logic [SizeW-1:0] size;
    logic             phase;
  } send_slot_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  oops_item_if   item_ch ();
  oops_result_if result_ch ();
  oops_cfg_if    cfg_ch ();

  on_off_packet_scheduler dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (item_ch),
    .out_o  (result_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Register shadow
  logic [31:0]      gap_first_ns, gap_second_ns, len_first_us, len_second_us;
  logic [SizeW-1:0] bytes_first, bytes_second;

  // Schedule shadow
  logic [SecW-1:0] t_sec, mark_sec;
  logic [31:0]     t_ns;
  logic [UsW-1:0]  mark_us;
  logic            on_second;

  send_slot_t  expected_sends[$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned cycles;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned stall_left;
  bit          quiet;

  // Move the phase start forward by the span; the send time follows it.
  function automatic void jump_phase(logic [31:0] span);
    logic [63:0] t;
    t = 64'(mark_us) + 64'(span);
    mark_sec = mark_sec + 32'(t / UsPerSec);
    mark_us = UsW'(t % UsPerSec);
    t_sec = mark_sec;
    t_ns = mark_us * NsPerUs;
  endfunction

  function automatic void add_gap(logic [31:0] gap);
    logic [63:0] t;
    t = 64'(t_ns) + 64'(gap);
    t_sec = t_sec + 32'(t / 64'd1000000000);
    t_ns = 32'(t % 64'd1000000000);
  endfunction

  // Elapsed time wraps in 64 bits, so a send time before the mark counts as past.
  function automatic bit past_span(logic [31:0] span);
    logic [31:0] dsec;
    logic [63:0] elapsed;
    dsec = t_sec - mark_sec;
    elapsed = 64'(dsec) * 64'(UsPerSec) + 64'(t_ns / NsPerUs) - 64'(mark_us);
    return elapsed > 64'(span);
  endfunction

  function automatic void predict_send_time(op_e op, logic [SecW-1:0] bsec,
                                            logic [UsW-1:0] bus);
    send_slot_t s;
    logic [UsW-1:0] us_sat;
    if (op == OP_START) begin
      us_sat = (bus > UsMax) ? UsW'(UsMax) : bus;
      t_sec = bsec;
      t_ns = us_sat * NsPerUs;
      mark_sec = bsec;
      mark_us = us_sat;
      on_second = 1'b0;
      if (gap_first_ns == 0) begin
        jump_phase(len_first_us);
        on_second = 1'b1;
      end
    end else if (!on_second) begin
      if (gap_first_ns == 0) begin
        jump_phase(len_first_us);
        on_second = 1'b1;
      end else begin
        add_gap(gap_first_ns);
        if (past_span(len_first_us)) begin
          on_second = 1'b1;
          jump_phase(len_first_us);
        end
      end
    end else begin
      if (gap_second_ns == 0) begin
        jump_phase(len_second_us);
        on_second = 1'b0;
      end else begin
        add_gap(gap_second_ns);
        if (len_second_us != 0 && past_span(len_second_us)) begin
          on_second = 1'b0;
          jump_phase(len_second_us);
        end
      end
    end
    s.sec = t_sec;
    s.us = UsW'(t_ns / NsPerUs);
    s.size = on_second ? bytes_second : bytes_first;
    s.phase = on_second;
    expected_sends.push_back(s);
  endfunction

  // Receiver: stall in random bursts.
  always @(posedge clk_i) begin
    if (!quiet && stall_left == 0 && stall_pct != 0 && $urandom_range(1, 100) <= stall_pct)
      stall_left = $urandom_range(1, 8);
    if (stall_left != 0) begin
      result_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_results
    send_slot_t want, got;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      got.sec = result_ch.send_sec;
      got.us = result_ch.send_us;
      got.size = result_ch.packet_size;
      got.phase = result_ch.phase;
      if (expected_sends.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result: sec=%h us=%0d size=%0d phase=%0d",
                   got.sec, got.us, got.size, got.phase);
      end else begin
        want = expected_sends.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("mismatch sec/us/size/phase: expected %h/%0d/%0d/%0d, got %h/%0d/%0d/%0d",
                     want.sec, want.us, want.size, want.phase,
                     got.sec, got.us, got.size, got.phase);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(op_e op, logic [SecW-1:0] bsec = '0, logic [UsW-1:0] bus = '0);
    if (!quiet && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.opcode <= op;
    item_ch.base_sec <= bsec;
    item_ch.base_us <= bus;
    @(posedge clk_i);
    while (!item_ch.ready) @(posedge clk_i);
    predict_send_time(op, bsec, bus);
    items_sent++;
  endtask

  // Hold the sender until every result is back, then let the block settle.
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (expected_sends.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    case (idx)
      REG_PERIOD_FIRST:  gap_first_ns = val;
      REG_PERIOD_SECOND: gap_second_ns = val;
      REG_SIZE_FIRST:    bytes_first = val[SizeW-1:0];
      REG_SIZE_SECOND:   bytes_second = val[SizeW-1:0];
      REG_SPAN_FIRST:    len_first_us = val;
      REG_SPAN_SECOND:   len_second_us = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic [31:0] p1, logic [31:0] p2, logic [SizeW-1:0] s1,
                           logic [SizeW-1:0] s2, logic [31:0] l1, logic [31:0] l2);
    wait_idle();
    write_reg(REG_PERIOD_FIRST, p1);
    write_reg(REG_PERIOD_SECOND, p2);
    write_reg(REG_SIZE_FIRST, 32'(s1));
    write_reg(REG_SIZE_SECOND, 32'(s2));
    write_reg(REG_SPAN_FIRST, l1);
    write_reg(REG_SPAN_SECOND, l2);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_period();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(1, 20_000_000);
    endcase
  endfunction

  function automatic logic [31:0] pick_span();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom();
      default: return $urandom_range(0, 60_000);
    endcase
  endfunction

  // Advance before any start, with the reset registers: both phases silent.
  task automatic test_reset_state();
    send_item(OP_ADVANCE);
    send_item(OP_ADVANCE);
    send_item(OP_START, 32'hFFFF_FFFF, 20'hFFFFF);
  endtask

  task automatic test_time_extremes();
    configure(32'd1000, 32'd2000, 16'd0, 16'hFFFF, 32'd5, 32'd0);
    send_item(OP_START, 32'd0, 20'd0);
    send_item(OP_ADVANCE);
    // Carry microseconds across the second wrap, then leave the first phase
    // for an endless second one.
    send_item(OP_START, 32'hFFFF_FFFF, 20'd999999);
    repeat (8) send_item(OP_ADVANCE);
    send_item(OP_START, 32'h8000_0000, 20'd1000000);
    send_item(OP_START, 32'h7FFF_FFFF, 20'hFFFFF);
  endtask

  task automatic test_silent_phases();
    configure(32'd0, 32'hFFFF_FFFF, 16'h5555, 16'hAAAA, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_START, 32'h1234_5678, 20'd123456);
    repeat (2) send_item(OP_ADVANCE);
    // Zero spans: every packet overruns, and a silent second phase is not endless.
    configure(32'hFFFF_FFFF, 32'd0, 16'(SizeReset), 16'd1, 32'd0, 32'd0);
    send_item(OP_START, 32'd0, 20'd0);
    repeat (3) send_item(OP_ADVANCE);
  endtask

  task automatic test_random_schedule();
    int unsigned n, phase_no;
    logic [UsW-1:0] us;
    phase_no = 0;
    while (items_sent < RandomItems) begin
      configure(pick_period(), pick_period(), 16'($urandom), 16'($urandom),
                pick_span(), pick_span());
      case ($urandom_range(0, 3))
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 10; stall_pct = 30; end
        2: begin gap_pct = 30; stall_pct = 10; end
        default: begin gap_pct = 60; stall_pct = 60; end
      endcase
      if (items_sent > RandomItems - 100) quiet = 1'b1;
      n = $urandom_range(15, 35);
      for (int unsigned k = 0; k < n; k++) begin
        if (phase_no == 5 && k == n / 2) wait_idle();
        if (k == 0 || $urandom_range(0, 11) == 0) begin
          us = ($urandom_range(0, 9) == 0) ? UsW'($urandom) : UsW'($urandom_range(0, UsMax));
          send_item(OP_START, $urandom(), us);
        end else begin
          send_item(OP_ADVANCE);
        end
      end
      phase_no++;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    item_ch.valid = 1'b0;
    item_ch.opcode = OP_START;
    item_ch.base_sec = '0;
    item_ch.base_us = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_PERIOD_FIRST;
    cfg_ch.data = '0;
    gap_first_ns = '0;
    gap_second_ns = '0;
    len_first_us = '0;
    len_second_us = '0;
    bytes_first = SizeW'(SizeReset);
    bytes_second = SizeW'(SizeReset);
    t_sec = '0;
    t_ns = '0;
    mark_sec = '0;
    mark_us = '0;
    on_second = 1'b0;
    mismatches = 0;
    items_sent = 0;
    cycles = 0;
    gap_pct = 20;
    stall_pct = 20;
    stall_left = 0;
    quiet = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_time_extremes();
    test_silent_phases();
    test_random_schedule();

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_sends.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
